/* src/kdeq_pkg.sv */
// ----------------------------------------------------------------------------
// kdeq_pkg: shared types and constants
// Lane result record, operation codes and fixed field widths for the key
// debounce event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kdeq_pkg;

    localparam int CNT_W = 4;   // mismatch counter and threshold width
    localparam int KEY_W = 3;   // stored / reported key index width

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd2;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // what one debounce lane found on a scan
    typedef struct packed {
        logic             flip;     // debounced level toggles
        logic             press;    // toggle is towards pressed
        logic [CNT_W-1:0] cnt_new;  // counter value if this lane is updated
    } lane_res_t;

endpackage

`default_nettype wire

/* src/kdeq_ram.sv */
// ----------------------------------------------------------------------------
// kdeq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data that holds
// while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module kdeq_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/kdeq_lane.sv */
// ----------------------------------------------------------------------------
// kdeq_lane: debounce lane for one key
// Compares the sampled level with the debounced level and works out the
// counter step and whether the debounced level flips.
// ----------------------------------------------------------------------------
`default_nettype none

module kdeq_lane
    import kdeq_pkg::*;
(
    input  wire logic             level,
    input  wire logic             held,
    input  wire logic [CNT_W-1:0] cnt,
    input  wire logic [CNT_W-1:0] threshold,
    output      lane_res_t        res
);

    logic             mismatch;
    logic [CNT_W-1:0] cnt_inc;

    always_comb
    begin
        mismatch    = (level != held);
        cnt_inc     = cnt + CNT_W'(1);   // wraps at 4 bits
        res.flip    = mismatch && (cnt_inc >= threshold);
        res.press   = res.flip && !level;
        res.cnt_new = (!mismatch || res.flip) ? '0 : cnt_inc;
    end

endmodule

`default_nettype wire

/* src/kdeq_merge.sv */
// ----------------------------------------------------------------------------
// kdeq_merge: combine lane results
// The lowest pressing key ends the scan; lanes above it keep their state.
// ----------------------------------------------------------------------------
`default_nettype none

module kdeq_merge
    import kdeq_pkg::*;
#(
    parameter int NUM_KEYS = 6
) (
    input  wire lane_res_t [NUM_KEYS-1:0]             res,
    input  wire logic      [NUM_KEYS-1:0]             held,
    input  wire logic      [NUM_KEYS-1:0][CNT_W-1:0]  cnt,
    output      logic                                 fired,
    output      logic      [KEY_W-1:0]                fired_key,
    output      logic      [NUM_KEYS-1:0]             held_next,
    output      logic      [NUM_KEYS-1:0][CNT_W-1:0]  cnt_next
);

    logic seen;

    always_comb
    begin
        seen      = 1'b0;
        fired_key = '0;
        held_next = held;
        cnt_next  = cnt;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (!seen)
            begin
                held_next[i] = held[i] ^ res[i].flip;
                cnt_next[i]  = res[i].cnt_new;
                if (res[i].press)
                begin
                    seen      = 1'b1;
                    fired_key = KEY_W'(i);
                end
            end
        end
        fired = seen;
    end

endmodule

`default_nettype wire

/* src/key_debounce_event_queue_core.sv */
// ----------------------------------------------------------------------------
// key_debounce_event_queue_core: key debounce with press-event ring
// The result is registered by the clock edge that accepts the item.
// Throughput: one item per cycle; in_ready falls only while a result waits.
// Pop data comes from the ring RAM's registered read port, read at accept.
// Reset: keys released, counters and ring pointers cleared, threshold 2.
// Ring contents are not cleared; only written slots are ever popped.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_event_queue_core
    import kdeq_pkg::*;
#(
    parameter int NUM_KEYS    = 6,
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    // configuration: debounce threshold
    input  wire logic                cfg_write_en,
    input  wire logic [CNT_W-1:0]    cfg_write_data,

    // item input
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic                operation,
    input  wire logic [NUM_KEYS-1:0] key_levels,

    // result output
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic                scan_fired,
    output      logic [KEY_W-1:0]    scan_key,
    output      logic                event_dropped,
    output      logic                pop_valid,
    output      logic [KEY_W-1:0]    pop_key
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    // ---------------- state ----------------
    logic [CNT_W-1:0]               thr_reg;
    logic [NUM_KEYS-1:0]            held_reg, held_next;
    logic [NUM_KEYS-1:0][CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]                  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]                  rd_ptr_reg, rd_ptr_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           fired_reg, fired_next;
    logic [KEY_W-1:0]               key_reg, key_next;
    logic                           drop_reg, drop_next;
    logic                           popv_reg, popv_next;

    // ---------------- per-key lanes ----------------
    lane_res_t [NUM_KEYS-1:0]       lane_res;
    logic [NUM_KEYS-1:0]            scan_held;
    logic [NUM_KEYS-1:0][CNT_W-1:0] scan_cnt;
    logic                           scan_hit;
    logic [KEY_W-1:0]               scan_hit_key;

    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lane
        kdeq_lane u_lane (
            .level     (key_levels[g]),
            .held      (held_reg[g]),
            .cnt       (cnt_reg[g]),
            .threshold (thr_reg),
            .res       (lane_res[g])
        );
    end

    // lowest pressing key wins and freezes the lanes above it
    kdeq_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .res       (lane_res),
        .held      (held_reg),
        .cnt       (cnt_reg),
        .fired     (scan_hit),
        .fired_key (scan_hit_key),
        .held_next (scan_held),
        .cnt_next  (scan_cnt)
    );

    // ---------------- ring control ----------------
    logic          accept;
    logic          is_pop;
    logic [PW-1:0] wr_ptr_inc, rd_ptr_inc;
    logic          ring_full, ring_empty;
    logic          push_we, pop_re;
    logic [KEY_W-1:0] ram_rdata;

    always_comb
    begin
        wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        // one slot stays empty so full and empty differ
        ring_full  = (wr_ptr_inc == rd_ptr_reg);
        ring_empty = (wr_ptr_reg == rd_ptr_reg);
    end

    // a new item goes in whenever the result register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_pop   = (operation == OP_POP);
    assign push_we  = accept && !is_pop && scan_hit && !ring_full;
    assign pop_re   = accept && is_pop && !ring_empty;

    // read data is held by the RAM until the next pop is accepted, which
    // can only happen once the current result has been taken
    kdeq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (push_we),
        .waddr (wr_ptr_reg),
        .wdata (scan_hit_key),
        .re    (pop_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        out_valid_next = out_valid_reg;
        fired_next     = fired_reg;
        key_next       = key_reg;
        drop_next      = drop_reg;
        popv_next      = popv_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            if (is_pop)
            begin
                fired_next = 1'b0;
                key_next   = '0;
                drop_next  = 1'b0;
                popv_next  = !ring_empty;
                if (!ring_empty)
                begin
                    rd_ptr_next = rd_ptr_inc;
                end
            end
            else
            begin
                held_next  = scan_held;
                cnt_next   = scan_cnt;
                fired_next = scan_hit;
                key_next   = scan_hit ? scan_hit_key : '0;
                drop_next  = scan_hit && ring_full;
                popv_next  = 1'b0;
                if (push_we)
                begin
                    wr_ptr_next = wr_ptr_inc;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THRESHOLD_RESET;
            held_reg      <= '1;
            cnt_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                thr_reg <= cfg_write_data;
            end
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        fired_reg <= fired_next;
        key_reg   <= key_next;
        drop_reg  <= drop_next;
        popv_reg  <= popv_next;
    end

    assign out_valid     = out_valid_reg;
    assign scan_fired    = fired_reg;
    assign scan_key      = key_reg;
    assign event_dropped = drop_reg;
    assign pop_valid     = popv_reg;
    assign pop_key       = popv_reg ? ram_rdata : '0;

    // ---------------- checks ----------------
    a_scan_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(scan_fired && pop_valid))
        else $error("scan and pop result in one item");

    a_drop_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_dropped |-> scan_fired)
        else $error("drop flagged without a fired scan");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_pop && ring_empty |=> out_valid && !pop_valid)
        else $error("pop on empty ring returned an event");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        ring_full && !pop_re |=> $stable(wr_ptr_reg))
        else $error("write pointer moved while ring full");

endmodule

`default_nettype wire
